>>> rtl/pdc_pkg.sv
// pdc_pkg: shared constants for the PWM period and duty capture block.
// Default widths and the sideband bit layout used by the top level and its checker.
// No dependencies.
package pdc_pkg;

	// default widths of the timer stamps and of the duty fraction
	localparam int TIMER_BITS_DEF     = 16;
	localparam int DUTY_FRAC_BITS_DEF = 16;

	// bit positions inside m_tuser
	localparam int TUSER_DONE_BIT  = 0;
	localparam int TUSER_PZERO_BIT = 1;
	localparam int TUSER_W         = 2;

endpackage

>>> rtl/pwm_period_duty_capture_top.sv
// pwm_period_duty_capture_top: PWM period and duty measurement from capture stamps.
// The first rising stamp goes straight to the output register; the second rising stamp
// passes a serial subtract, the falling stamp a serial subtract and a divide (one quotient
// bit a cycle) that ends at once when the period is zero or the high time reaches it.
// One stamp at a time: s_tready is low until the last result is in the output register.
// Reset: arst_n low clears phase and results. Uses pdc_pkg, pdc_sub_serial, pdc_div_serial.
module pwm_period_duty_capture_top #(
	parameter int TIMER_BITS     = pdc_pkg::TIMER_BITS_DEF,
	parameter int DUTY_FRAC_BITS = pdc_pkg::DUTY_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,

	// capture stamps in
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// s_tdata: capture_time, zero padded to whole bytes
	input  logic [((TIMER_BITS + 7) / 8) * 8 - 1:0] s_tdata,

	// measurement results out
	output logic m_tvalid,
	input  logic m_tready,
	// m_tdata from bit 0 up: edge_select, period_ticks, high_ticks, duty_fraction, zero pad
	output logic [((2 * TIMER_BITS + DUTY_FRAC_BITS + 2 + 7) / 8) * 8 - 1:0] m_tdata,
	// m_tuser from bit 0 up: measurement_done, period_zero
	output logic [pdc_pkg::TUSER_W-1:0] m_tuser
);

	localparam int DUTY_W  = DUTY_FRAC_BITS + 1;
	localparam int FIELD_W = 2 * TIMER_BITS + DUTY_W + 1;
	localparam int OUT_W   = ((FIELD_W + 7) / 8) * 8;

	// measurement phase, the unused code behaves as the first one
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_FALL   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SUB  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [1:0]              phase_q;
	logic [TIMER_BITS-1:0]   first_q;
	logic [TIMER_BITS-1:0]   second_q;
	logic [TIMER_BITS-1:0]   period_q;
	logic [TIMER_BITS-1:0]   high_q;
	logic [DUTY_W-1:0]       duty_q;
	logic                    edge_q;
	logic                    done_q;
	logic                    pzero_q;

	logic                    out_valid_q;
	logic [OUT_W-1:0]        out_data_q;
	logic [pdc_pkg::TUSER_W-1:0] out_user_q;

	logic                    in_xfer;
	logic                    emit_load;
	logic [TIMER_BITS-1:0]   stamp;
	logic                    sub_start;
	logic [TIMER_BITS-1:0]   sub_b;
	logic                    sub_done;
	logic [TIMER_BITS-1:0]   sub_diff;
	logic                    div_start;
	logic                    div_done;
	logic [DUTY_W-1:0]       div_quot;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign stamp     = s_tdata[TIMER_BITS-1:0];
	// load the output register once the previous transfer has gone
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || m_tready);

	// second rising edge subtracts the first stamp, the falling edge the second one
	assign sub_start = in_xfer && (phase_q == PH_SECOND || phase_q == PH_FALL);
	assign sub_b     = (phase_q == PH_SECOND) ? first_q : second_q;
	assign div_start = (state_q == ST_SUB) && sub_done && (phase_q == PH_FALL);

	pdc_sub_serial #(
		.W (TIMER_BITS)
	) u_sub (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (sub_start),
		.minuend    (stamp),
		.subtrahend (sub_b),
		.done       (sub_done),
		.diff       (sub_diff)
	);

	pdc_div_serial #(
		.NW (TIMER_BITS),
		.FW (DUTY_FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sub_diff),
		.den    (period_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// phase sequencer and measurement registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_FIRST;
			first_q  <= '0;
			second_q <= '0;
			period_q <= '0;
			high_q   <= '0;
			duty_q   <= '0;
			edge_q   <= 1'b0;
			done_q   <= 1'b0;
			pzero_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						case (phase_q)
							PH_SECOND: begin
								second_q <= stamp;
								state_q  <= ST_SUB;
							end
							PH_FALL: begin
								state_q <= ST_SUB;
							end
							default: begin
								// hold the first rising stamp, report nothing new
								first_q <= stamp;
								edge_q  <= 1'b0;
								done_q  <= 1'b0;
								pzero_q <= 1'b0;
								phase_q <= PH_SECOND;
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_SUB: begin
					if (sub_done) begin
						if (phase_q == PH_SECOND) begin
							// period known, ask for the falling edge
							period_q <= sub_diff;
							edge_q   <= 1'b1;
							done_q   <= 1'b0;
							pzero_q  <= 1'b0;
							phase_q  <= PH_FALL;
							state_q  <= ST_EMIT;
						end else begin
							high_q  <= sub_diff;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						duty_q  <= div_quot;
						edge_q  <= 1'b0;
						done_q  <= 1'b1;
						pzero_q <= (period_q == '0);
						phase_q <= PH_FIRST;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_data_q <= OUT_W'({duty_q, high_q, period_q, edge_q});
			out_user_q[pdc_pkg::TUSER_DONE_BIT]  <= done_q;
			out_user_q[pdc_pkg::TUSER_PZERO_BIT] <= pzero_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

>>> rtl/pdc_sub_serial.sv
// pdc_sub_serial: bit-serial modulo-2^W subtractor, one bit per cycle, LSB first.
// Operands and result live in shift registers; no package dependencies.
module pdc_sub_serial #(
	parameter int W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] minuend,
	input  logic [W-1:0] subtrahend,
	output logic         done,
	output logic [W-1:0] diff
);

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     a_q;
	logic [W-1:0]     b_q;
	logic [W-1:0]     diff_q;
	logic             borrow_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic             dbit;
	logic             borrow_nxt;

	// full subtractor on the low bits of both operands
	assign dbit       = a_q[0] ^ b_q[0] ^ borrow_q;
	assign borrow_nxt = (~a_q[0] & b_q[0]) | (~(a_q[0] ^ b_q[0]) & borrow_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q      <= minuend;
			b_q      <= subtrahend;
			borrow_q <= 1'b0;
		end else if (cnt_q != '0) begin
			a_q      <= {1'b0, a_q[W-1:1]};
			b_q      <= {1'b0, b_q[W-1:1]};
			borrow_q <= borrow_nxt;
			diff_q   <= {dbit, diff_q[W-1:1]};
		end
	end

	assign done = done_q;
	assign diff = diff_q;

endmodule

>>> rtl/pdc_div_serial.sv
// pdc_div_serial: restoring divider giving floor(num * 2^FW / den), one quotient bit per cycle.
// Saturates at 2^FW when num >= den and returns 0 for a zero divisor; no package dependencies.
module pdc_div_serial #(
	parameter int NW = 16,
	parameter int FW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	output logic          done,
	output logic [FW:0]   quot
);

	localparam int CNT_W = $clog2(FW + 1);

	logic [NW-1:0]    rem_q;
	logic [NW-1:0]    den_q;
	logic [FW:0]      quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [NW:0]      rem_dbl;
	logic             fits;

	// partial remainder stays below den, so doubling fits in NW+1 bits
	assign rem_dbl = {rem_q, 1'b0};
	assign fits    = (rem_dbl >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (start) begin
				// zero divisor or saturation finish at once
				if (den == '0 || num >= den) begin
					cnt_q  <= '0;
					done_q <= 1'b1;
				end else begin
					cnt_q  <= CNT_W'(FW);
					done_q <= 1'b0;
				end
			end else begin
				done_q <= (cnt_q == CNT_W'(1));
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			if (den == '0) begin
				quot_q <= '0;
			end else if (num >= den) begin
				quot_q <= {1'b1, {FW{1'b0}}};
			end else begin
				quot_q <= '0;
			end
		end else if (cnt_q != '0) begin
			rem_q  <= fits ? NW'(rem_dbl - {1'b0, den_q}) : rem_dbl[NW-1:0];
			quot_q <= {quot_q[FW-1:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> rtl/pdc_checker.sv
// pdc_checker: port-level assertions for pwm_period_duty_capture_top, bound to it below.
// Depends on pdc_pkg for the sideband bit layout.
module pdc_checker #(
	parameter int TIMER_BITS     = pdc_pkg::TIMER_BITS_DEF,
	parameter int DUTY_FRAC_BITS = pdc_pkg::DUTY_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((2 * TIMER_BITS + DUTY_FRAC_BITS + 2 + 7) / 8) * 8 - 1:0] m_tdata,
	input logic [pdc_pkg::TUSER_W-1:0] m_tuser
);

	localparam int PER_LO  = 1;
	localparam int DUTY_LO = 2 * TIMER_BITS + 1;

	logic done_flag;
	logic pzero_flag;

	assign done_flag  = m_tuser[pdc_pkg::TUSER_DONE_BIT];
	assign pzero_flag = m_tuser[pdc_pkg::TUSER_PZERO_BIT];

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	// a completed measurement always re-arms the rising edge
	a_done_rising: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && done_flag |-> m_tdata[0] == 1'b0)
		else $error("completed measurement requests falling edge");

	// zero period only flags a completed measurement, with zero period and duty
	a_pzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && pzero_flag |-> done_flag
			&& m_tdata[PER_LO +: TIMER_BITS] == '0
			&& m_tdata[DUTY_LO +: DUTY_FRAC_BITS + 1] == '0)
		else $error("zero period flag inconsistent with result");

	// duty never exceeds one
	a_duty_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[DUTY_LO + DUTY_FRAC_BITS] |->
			m_tdata[DUTY_LO +: DUTY_FRAC_BITS] == '0)
		else $error("duty fraction above one");

endmodule

bind pwm_period_duty_capture_top pdc_checker #(
	.TIMER_BITS     (TIMER_BITS),
	.DUTY_FRAC_BITS (DUTY_FRAC_BITS)
) u_pdc_checker (.*);
